// File: rtl/bsd_pkg.sv
// shared types, codes and the character table of the base64 stream decoder
package bsd_pkg;

	localparam int QUEUE_DEPTH = 4;

	// result status codes
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
	localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

	// special sextet codes from the character table
	localparam logic [6:0] SEXTET_PAD = 7'd64;
	localparam logic [6:0] SEXTET_BAD = 7'd65;

	// one queued command: up to three results from one input transfer
	typedef struct packed {
		logic [23:0] bytes;     // msb first
		logic [1:0]  last_idx;  // index of the final result, 0..2
		logic [1:0]  status;
		logic        eom;
	} cmd_t;

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] v;
		begin
			v = SEXTET_BAD;
			if (c >= 8'h41 && c <= 8'h5a) begin
				v = 7'(c - 8'h41);
			end else if (c >= 8'h61 && c <= 8'h7a) begin
				v = 7'(c - 8'h61 + 8'd26);
			end else if (c >= 8'h30 && c <= 8'h39) begin
				v = 7'(c - 8'h30 + 8'd52);
			end else if (c == 8'h2b) begin
				v = 7'd62;
			end else if (c == 8'h2f) begin
				v = 7'd63;
			end else if (c == 8'h3d) begin
				v = SEXTET_PAD;
			end
			return v;
		end
	endfunction

endpackage

// File: rtl/bsd_front.sv
// front end: character classification, quad accumulation and command generation
module bsd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    char_code,
	input  logic          end_of_message,
	output logic          push,
	output bsd_pkg::cmd_t push_cmd
);
	import bsd_pkg::*;

	logic [23:0] acc_q, acc_d;
	logic [1:0]  qpos_q, qpos_d;
	logic [2:0]  pad_q, pad_d;
	logic        err_q, err_d;

	logic [6:0]  sextet;
	logic [2:0]  pad_nxt;
	logic [23:0] acc_nxt;

	assign sextet  = sextet_of(char_code);
	assign pad_nxt = (sextet == SEXTET_PAD && pad_q != 3'd7) ? pad_q + 3'd1 : pad_q;
	// pad enters as zero
	assign acc_nxt = {acc_q[17:0], (sextet == SEXTET_PAD) ? 6'd0 : sextet[5:0]};

	always_comb begin
		acc_d    = acc_q;
		qpos_d   = qpos_q;
		pad_d    = pad_q;
		err_d    = err_q;
		push     = 1'b0;
		push_cmd = '0;
		push_cmd.eom = end_of_message;
		if (accept) begin
			if (err_q) begin
				// dropping until end of message
				if (end_of_message) begin
					acc_d  = '0;
					qpos_d = '0;
					pad_d  = '0;
					err_d  = 1'b0;
				end
			end else if (sextet == SEXTET_BAD) begin
				push            = 1'b1;
				push_cmd.status = STATUS_BAD_CHAR;
				if (end_of_message) begin
					acc_d  = '0;
					qpos_d = '0;
					pad_d  = '0;
				end else begin
					err_d = 1'b1;
				end
			end else if (qpos_q == 2'd3) begin
				push            = 1'b1;
				push_cmd.status = STATUS_OK;
				push_cmd.bytes  = acc_nxt;
				case (pad_nxt)
					3'd1:    push_cmd.last_idx = 2'd1;
					3'd2:    push_cmd.last_idx = 2'd0;
					default: push_cmd.last_idx = 2'd2;
				endcase
				acc_d  = '0;
				qpos_d = '0;
				pad_d  = '0;
			end else if (end_of_message) begin
				// message ends inside a quad
				push            = 1'b1;
				push_cmd.status = STATUS_BAD_LENGTH;
				acc_d  = '0;
				qpos_d = '0;
				pad_d  = '0;
			end else begin
				acc_d  = acc_nxt;
				qpos_d = qpos_q + 2'd1;
				pad_d  = pad_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			qpos_q <= '0;
			pad_q  <= '0;
			err_q  <= 1'b0;
		end else begin
			acc_q  <= acc_d;
			qpos_q <= qpos_d;
			pad_q  <= pad_d;
			err_q  <= err_d;
		end
	end

	a_eom_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_message) |=> (qpos_q == 2'd0 && pad_q == 3'd0 && !err_q))
		else $error("state not cleared after end of message");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> !push)
		else $error("command issued while dropping after an error");

	a_pad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q <= {1'b0, qpos_q})
		else $error("pad count exceeds characters in quad");

endmodule

// File: rtl/bsd_queue.sv
// command queue between front and back end
module bsd_queue #(
	parameter int Depth = bsd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bsd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output bsd_pkg::cmd_t head_cmd
);
	import bsd_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign full       = (cnt_q == CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop && head_valid) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push && !full, pop && head_valid})
				2'b10:   cnt_q <= cnt_q + CntW'(1);
				2'b01:   cnt_q <= cnt_q - CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("pop from empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("queue count out of range");

endmodule

// File: rtl/bsd_back.sv
// back end: queued commands to the output register, one result per cycle unless stalled
module bsd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  bsd_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          result_valid,
	input  logic          result_ready,
	output logic [7:0]    data_byte,
	output logic [1:0]    status,
	output logic          run_last,
	output logic          message_done
);
	import bsd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic       last_q;
	logic       done_q;

	logic       load;
	logic       is_last;
	logic [7:0] byte_sel;

	assign load    = head_valid && (!valid_q || result_ready);
	assign is_last = (idx_q == head_cmd.last_idx);
	assign pop     = load && is_last;

	always_comb begin
		case (idx_q)
			2'd0:    byte_sel = head_cmd.bytes[23:16];
			2'd1:    byte_sel = head_cmd.bytes[15:8];
			default: byte_sel = head_cmd.bytes[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_sel;
			status_q <= head_cmd.status;
			last_q   <= is_last;
			done_q   <= is_last && head_cmd.eom;
		end
	end

	assign result_valid = valid_q;
	assign data_byte    = byte_q;
	assign status       = status_q;
	assign run_last     = last_q;
	assign message_done = done_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (!done_q || last_q))
		else $error("message_done without run_last");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && status_q != STATUS_OK) |-> (last_q && byte_q == 8'd0))
		else $error("error result not a single zero result");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head_cmd.last_idx))
		else $error("result index past end of command");

endmodule

// File: rtl/base64_stream_decoder_top.sv
// top level of the streaming base64 decoder
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  char    | char_valid, char_ready, char_code, end_of_message | in
//  result  | result_valid, result_ready, data_byte, status,    | out
//          | run_last, message_done                            |
//
// one character transfer per cycle while char_ready is high, classified in the same cycle
// the back end sends a result per unstalled cycle; a 4-character quad gives up to 3 results
// the first result reaches the output register through the command queue after its transfer
// char_ready drops only while the command queue is full; the queue absorbs result stalls
// reset clears the quad and error state, the queue pointers and the result valid flag
module base64_stream_decoder_top #(
	parameter int QueueDepth = bsd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_message,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] data_byte,
	output logic [1:0] status,
	output logic       run_last,
	output logic       message_done
);
	import bsd_pkg::*;

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	assign char_ready = !full;
	assign accept     = char_valid && char_ready;

	bsd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.char_code      (char_code),
		.end_of_message (end_of_message),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	bsd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	bsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.data_byte    (data_byte),
		.status       (status),
		.run_last     (run_last),
		.message_done (message_done)
	);

endmodule

// File: sim/tb_base64_stream_decoder_top.sv
// testbench for base64_stream_decoder_top: directed rows, then random messages checked by a predictor
`timescale 1ns / 1ps

module tb_base64_stream_decoder_top;
	import bsd_pkg::*;

	localparam int RANDOM_CHARS = 105;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PAD_VALUE = 64;
	localparam int BAD_VALUE = -1;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] st;
		logic       last;
		logic       done;
	} decode_result_t;

	// typed rows carry their own result (none or one); other rows go to the predictor
	typedef struct packed {
		logic [7:0] code;
		logic       eom;
		logic       typed;
		logic       n_typed;
		logic [1:0] t_status;
		logic       t_done;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_ready;
	logic [7:0] char_code = 8'h00;
	logic       end_of_message = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] data_byte;
	logic [1:0] status;
	logic       run_last;
	logic       message_done;

	// decoder state as the predictor sees it
	logic [23:0] acc = '0;
	logic [1:0]  quad_pos = '0;
	logic [2:0]  pads = '0;
	logic        in_error = 1'b0;

	decode_result_t results_due [$];
	int  failures = 0;
	int  cycles = 0;
	bit  calm = 1'b0;

	stim_row_t directed_rows [25] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, STATUS_BAD_CHAR, 1'b0},
		'{"A", 1'b0, 1'b1, 1'b0, STATUS_OK, 1'b0},
		'{"B", 1'b1, 1'b1, 1'b0, STATUS_OK, 1'b0},
		'{"A", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"A", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"A", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"A", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"/", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"/", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"/", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"/", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"+", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"9", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"c", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"=", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"a", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"0", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"=", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"=", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"=", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"=", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"=", 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"=", 1'b1, 1'b0, 1'b0, STATUS_OK, 1'b0},
		'{"z", 1'b1, 1'b1, 1'b1, STATUS_BAD_LENGTH, 1'b1},
		'{8'hff, 1'b1, 1'b1, 1'b1, STATUS_BAD_CHAR, 1'b1}
	};

	base64_stream_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_code(char_code),
		.end_of_message(end_of_message),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.data_byte(data_byte),
		.status(status),
		.run_last(run_last),
		.message_done(message_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int sextet_value(logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - int'("A");
		if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
		if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
		if (c == "+") return 62;
		if (c == "/") return 63;
		if (c == "=") return PAD_VALUE;
		return BAD_VALUE;
	endfunction

	function automatic logic [7:0] char_of(int v);
		if (v < 26) return 8'(int'("A") + v);
		if (v < 52) return 8'(int'("a") + v - 26);
		if (v < 62) return 8'(int'("0") + v - 52);
		if (v == 62) return "+";
		return "/";
	endfunction

	function automatic logic [7:0] bad_code();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (sextet_value(c) != BAD_VALUE);
		return c;
	endfunction

	function automatic void clear_state();
		acc = '0;
		quad_pos = '0;
		pads = '0;
		in_error = 1'b0;
	endfunction

	function automatic void add_due(bit keep, logic [7:0] b, logic [1:0] st, logic last,
			logic done);
		if (keep)
			results_due.push_back('{b, st, last, done});
	endfunction

	// advance the decoder by one character; keep=0 updates state only
	function automatic void decode_char(logic [7:0] c, logic eom, bit keep);
		int v;
		int n;
		if (in_error) begin
			if (eom)
				clear_state();
			return;
		end
		v = sextet_value(c);
		if (v == BAD_VALUE) begin
			add_due(keep, 8'h00, STATUS_BAD_CHAR, 1'b1, eom);
			if (eom)
				clear_state();
			else
				in_error = 1'b1;
			return;
		end
		if (v == PAD_VALUE) begin
			v = 0;
			if (pads < 3'd7)
				pads = pads + 3'd1;
		end
		acc = {acc[17:0], 6'(v)};
		if (quad_pos == 2'd3) begin
			n = (pads == 3'd1) ? 2 : (pads == 3'd2) ? 1 : 3;
			for (int i = 0; i < n; i++)
				add_due(keep, acc[23 - 8 * i -: 8], STATUS_OK, i == n - 1, (i == n - 1) && eom);
			clear_state();
			return;
		end
		quad_pos = quad_pos + 2'd1;
		if (eom) begin
			add_due(keep, 8'h00, STATUS_BAD_LENGTH, 1'b1, 1'b1);
			clear_state();
		end
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_char(logic [7:0] c, logic eom, logic typed, logic n_typed,
			logic [1:0] t_status, logic t_done);
		int gap;
		gap = idle_len();
		@(negedge clk);
		repeat (gap) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_code <= c;
		end_of_message <= eom;
		do begin
			@(posedge clk);
		end while (!char_ready);
		decode_char(c, eom, !typed);
		if (typed && n_typed)
			results_due.push_back('{8'h00, t_status, 1'b1, t_done});
	endtask

	task automatic wait_drained();
		@(negedge clk);
		char_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic void note_failure(string why, decode_result_t want, decode_result_t got);
		failures++;
		if (failures <= 10)
			$display("%0t %s: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
				$realtime, why, want.data, want.st, want.last, want.done,
				got.data, got.st, got.last, got.done);
	endfunction

	// result side: stalls of random length, with calm stretches
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					stall = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		decode_result_t got;
		decode_result_t want;
		if (arst_n && result_valid && result_ready) begin
			got = '{data_byte, status, run_last, message_done};
			if (results_due.size() == 0) begin
				note_failure("unexpected result transfer", got, got);
			end else begin
				want = results_due.pop_front();
				if (got.data !== want.data || got.st !== want.st || got.last !== want.last
						|| got.done !== want.done)
					note_failure("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [7:0] msg [$];
		int taken;
		int nq;
		int kind;
		int cut;
		taken = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_char(directed_rows[i].code, directed_rows[i].eom, directed_rows[i].typed,
				directed_rows[i].n_typed, directed_rows[i].t_status, directed_rows[i].t_done);
		wait_drained();

		while (taken < RANDOM_CHARS) begin
			calm = ($urandom_range(0, 3) == 0);
			msg.delete();
			nq = $urandom_range(1, 4);
			repeat (4 * nq)
				msg.push_back(char_of($urandom_range(0, 63)));
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				// proper tail padding
				cut = $urandom_range(0, 2);
				for (int k = 0; k < cut; k++)
					msg[msg.size() - 1 - k] = "=";
			end else if (kind < 70) begin
				repeat ($urandom_range(1, 4))
					msg[$urandom_range(0, msg.size() - 1)] = "=";
			end else if (kind < 82) begin
				msg[$urandom_range(0, msg.size() - 1)] = bad_code();
			end else if (kind < 92) begin
				repeat ($urandom_range(1, 3))
					void'(msg.pop_back());
			end else begin
				foreach (msg[k])
					msg[k] = 8'($urandom_range(0, 255));
			end
			foreach (msg[k]) begin
				taken++;
				send_char(msg[k], k == msg.size() - 1, 1'b0, 1'b0, STATUS_OK, 1'b0);
			end
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/bsd_pkg.sv
rtl/bsd_front.sv
rtl/bsd_queue.sv
rtl/bsd_back.sv
rtl/base64_stream_decoder_top.sv
sim/tb_base64_stream_decoder_top.sv
